FILE: hw/rtl/qdv_pkg.sv
// shared constants, codes and helpers for the quadrature decoder with velocity
package qdv_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // config register fields
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO_Q8  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DIR     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] CPR_RESET  = 16'd1;
    localparam logic [CFG_DATA_W-1:0] GEAR_RESET = 16'd256;

    // item codes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_EDGE_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    // serial multiplier operand width and its two constant operands
    localparam int MUL_B_W = 35;
    localparam logic [MUL_B_W-1:0] TWO_PI_Q32 = 35'd26986075409;
    localparam logic [MUL_B_W-1:0] US_PER_S   = 35'd1000000;

    // quotient magnitude to signed 32-bit with saturation
    function automatic logic [31:0] sat_sign(input logic [32:0] q, input logic ovf,
                                            input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (ovf || (q > 33'h0_8000_0000)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
        end else begin
            r = (ovf || q[32] || q[31]) ? 32'h7fff_ffff : q[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/quadrature_decoder_velocity.sv
// x4 quadrature decoder: wrapping count, shaft angle and velocity, bit-serial arithmetic
//
// Each transfer on the s_ channel is an edge on channel A or B or a velocity update tick,
// and gives one result on the m_ channel holding the count, the shaft angle in signed
// Q(FRAC_BITS) radians and the last velocity in Q(FRAC_BITS) rad/s. One item is in work
// at a time. The angle goes through a shift-add multiplier over a 35-bit operand and a
// restoring divider that takes one quotient bit per cycle over NW bits, where
// NW = max(COUNT_WIDTH+35, 56-FRAC_BITS, 53) (67 at the defaults). A tick with a nonzero
// time step runs the same multiplier and divider a second time for the velocity. A zero
// count or a zero divisor register skips the angle arithmetic. A finished result waits
// in the output register while the next item is taken in. Configuration is written
// through cfg_wr_en/cfg_index/cfg_wdata only while idle; the user must keep to this,
// as the block itself does not enforce it.
module quadrature_decoder_velocity #(
    parameter int COUNT_WIDTH = qdv_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = qdv_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [qdv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qdv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [qdv_pkg::MODE_W-1:0]        s_mode,
    input  logic                              s_level_a,
    input  logic                              s_level_b,
    input  logic [31:0]                       s_time_us,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_position_count,
    output logic signed [31:0]                m_angle_rad,
    output logic signed [31:0]                m_velocity_rad_s
);

    localparam int MB  = qdv_pkg::MUL_B_W;
    localparam int SH  = 24 - FRAC_BITS;
    localparam int DW  = 32 + SH;                               // divisor width
    localparam int AW  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32; // multiplicand width
    localparam int MW  = (DW > AW) ? DW : AW;
    localparam int UW  = MW + 2;                                // product upper part
    localparam int PW  = UW + MB;
    localparam int NA  = (COUNT_WIDTH + 35 > DW) ? COUNT_WIDTH + 35 : DW;
    localparam int NW  = (NA > 53) ? NA : 53;                   // dividend bits
    localparam int MCW = $clog2(MB);
    localparam int DCW = $clog2(NW);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_FIN   = 7'b0010000,
        ST_VPREP = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [15:0]            cpr_reg, cpr_next;
    logic [15:0]            gear_reg, gear_next;
    logic                   invert_reg, invert_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [31:0]            last_time_reg, last_time_next;
    logic [31:0]            last_angle_reg, last_angle_next;
    logic [31:0]            velocity_reg, velocity_next;
    logic [31:0]            angle_reg, angle_next;
    logic [1:0]             mode_reg, mode_next;
    logic [31:0]            time_reg, time_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [AW-1:0]          mul_a_reg, mul_a_next;
    logic [MB-1:0]          mul_b_reg, mul_b_next;
    logic [MCW-1:0]         mul_cnt_reg, mul_cnt_next;
    logic [PW-1:0]          p_reg, p_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [32:0]            q_reg, q_next;
    logic                   ovf_reg, ovf_next;
    logic [DCW-1:0]         div_cnt_reg, div_cnt_next;
    logic                   sign_reg, sign_next;
    logic                   phase_reg, phase_next;
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            m_count_reg, m_count_next;
    logic [31:0]            m_angle_reg, m_angle_next;
    logic [31:0]            m_vel_reg, m_vel_next;

    logic                   step_up;
    logic [31:0]            cpr_gear;
    logic                   cnt_neg;
    logic [COUNT_WIDTH-1:0] cnt_mag;
    logic [UW-1:0]          mul_sum;
    logic [DW:0]            div_shift;
    logic [DW:0]            div_diff;
    logic                   div_ge;
    logic [31:0]            fin_val;
    logic [31:0]            v_dt;
    logic [32:0]            v_diff;
    logic                   v_neg;
    logic [31:0]            v_mag;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_position_count = m_count_reg;
    assign m_angle_rad      = m_angle_reg;
    assign m_velocity_rad_s = m_vel_reg;

    always_comb begin
        step_up   = 1'b0;
        cpr_gear  = 32'(cpr_reg) * 32'(gear_reg);
        cnt_neg   = count_reg[COUNT_WIDTH-1];
        cnt_mag   = cnt_neg ? (~count_reg + COUNT_WIDTH'(1)) : count_reg;
        mul_sum   = p_reg[PW-1:MB] + (mul_b_reg[0] ? UW'(mul_a_reg) : UW'(0));
        div_shift = {rem_reg, p_reg[NW-1]};
        div_diff  = div_shift - {1'b0, d_reg};
        div_ge    = ~div_diff[DW];
        fin_val   = qdv_pkg::sat_sign(q_reg, ovf_reg, sign_reg);
        v_dt      = time_reg - last_time_reg;
        v_diff    = {angle_reg[31], angle_reg} - {last_angle_reg[31], last_angle_reg};
        v_neg     = v_diff[32];
        v_mag     = v_neg ? (~v_diff[31:0] + 32'd1) : v_diff[31:0];

        state_next      = state_reg;
        cpr_next        = cpr_reg;
        gear_next       = gear_reg;
        invert_next     = invert_reg;
        count_next      = count_reg;
        last_time_next  = last_time_reg;
        last_angle_next = last_angle_reg;
        velocity_next   = velocity_reg;
        angle_next      = angle_reg;
        mode_next       = mode_reg;
        time_next       = time_reg;
        d_next          = d_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        mul_cnt_next    = mul_cnt_reg;
        p_next          = p_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        ovf_next        = ovf_reg;
        div_cnt_next    = div_cnt_reg;
        sign_next       = sign_reg;
        phase_next      = phase_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_count_next    = m_count_reg;
        m_angle_next    = m_angle_reg;
        m_vel_next      = m_vel_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                qdv_pkg::CFG_COUNTS_PER_REV: cpr_next    = cfg_wdata;
                qdv_pkg::CFG_GEAR_RATIO_Q8:  gear_next   = cfg_wdata;
                qdv_pkg::CFG_INVERT_DIR:     invert_next = cfg_wdata[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        qdv_pkg::MODE_EDGE_A: begin
                            step_up    = s_level_a ^ s_level_b;
                            count_next = step_up ? count_reg + COUNT_WIDTH'(1)
                                                 : count_reg - COUNT_WIDTH'(1);
                        end
                        qdv_pkg::MODE_EDGE_B: begin
                            step_up    = ~(s_level_a ^ s_level_b);
                            count_next = step_up ? count_reg + COUNT_WIDTH'(1)
                                                 : count_reg - COUNT_WIDTH'(1);
                        end
                        default: ;
                    endcase
                    mode_next  = s_mode;
                    time_next  = s_time_us;
                    d_next     = DW'(cpr_gear) << SH;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                sign_next  = cnt_neg ^ invert_reg;
                q_next     = '0;
                ovf_next   = 1'b0;
                phase_next = 1'b0;
                if (cnt_mag == '0) begin
                    state_next = ST_FIN;
                end else if (d_reg == '0) begin
                    // zero divisor register: saturate toward the count's sign, flipped when inverted
                    ovf_next   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    mul_a_next   = AW'(cnt_mag);
                    mul_b_next   = qdv_pkg::TWO_PI_Q32;
                    // rounding half rides in the top and lands at bit 0 after the shifts
                    p_next       = PW'(d_reg >> 1) << MB;
                    mul_cnt_next = MCW'(MB - 1);
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                p_next     = {1'b0, mul_sum, p_reg[MB-1:1]};
                mul_b_next = mul_b_reg >> 1;
                if (mul_cnt_reg == '0) begin
                    rem_next     = '0;
                    q_next       = '0;
                    ovf_next     = 1'b0;
                    div_cnt_next = DCW'(NW - 1);
                    state_next   = ST_DIV;
                end else begin
                    mul_cnt_next = mul_cnt_reg - MCW'(1);
                end
            end
            ST_DIV: begin
                rem_next = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
                p_next   = p_reg << 1;
                q_next   = {q_reg[31:0], div_ge};
                ovf_next = ovf_reg | q_reg[32];
                if (div_cnt_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    div_cnt_next = div_cnt_reg - DCW'(1);
                end
            end
            ST_FIN: begin
                if (!phase_reg) begin
                    angle_next = fin_val;
                    state_next = (mode_reg == qdv_pkg::MODE_TICK) ? ST_VPREP : ST_DONE;
                end else begin
                    velocity_next   = fin_val;
                    last_time_next  = time_reg;
                    last_angle_next = angle_reg;
                    state_next      = ST_DONE;
                end
            end
            ST_VPREP: begin
                if (v_dt == '0) begin
                    // no time step: velocity holds, reference point moves
                    last_time_next  = time_reg;
                    last_angle_next = angle_reg;
                    state_next      = ST_DONE;
                end else begin
                    mul_a_next   = AW'(v_mag);
                    mul_b_next   = qdv_pkg::US_PER_S;
                    p_next       = PW'(v_dt >> 1) << MB;
                    d_next       = DW'(v_dt);
                    mul_cnt_next = MCW'(MB - 1);
                    sign_next    = v_neg;
                    phase_next   = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = 32'(count_reg);
                    m_angle_next = angle_reg;
                    m_vel_next   = velocity_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cpr_reg        <= qdv_pkg::CPR_RESET;
            gear_reg       <= qdv_pkg::GEAR_RESET;
            invert_reg     <= 1'b0;
            count_reg      <= '0;
            last_time_reg  <= '0;
            last_angle_reg <= '0;
            velocity_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cpr_reg        <= cpr_next;
            gear_reg       <= gear_next;
            invert_reg     <= invert_next;
            count_reg      <= count_next;
            last_time_reg  <= last_time_next;
            last_angle_reg <= last_angle_next;
            velocity_reg   <= velocity_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        angle_reg   <= angle_next;
        mode_reg    <= mode_next;
        time_reg    <= time_next;
        d_reg       <= d_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_cnt_reg <= mul_cnt_next;
        p_reg       <= p_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        ovf_reg     <= ovf_next;
        div_cnt_reg <= div_cnt_next;
        sign_reg    <= sign_next;
        phase_reg   <= phase_next;
        m_count_reg <= m_count_next;
        m_angle_reg <= m_angle_next;
        m_vel_reg   <= m_vel_next;
    end

    // one item at a time: a transfer is never followed at once by another
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    // the count moves only on an input transfer
    a_count_on_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg))) |-> $past(s_valid && s_ready))
        else $error("count changed without an input transfer");

    // velocity is written only when the velocity quotient is finished
    a_velocity_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (velocity_reg != $past(velocity_reg)))
            |-> $past(state_reg == ST_FIN && phase_reg))
        else $error("velocity changed outside its update");

    // the divider never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (d_reg != '0))
        else $error("divide step with zero divisor");

endmodule

FILE: sim/quadrature_decoder_velocity_tb.sv
// testbench for the quadrature decoder with shaft angle and velocity
`timescale 1ns / 1ps

module quadrature_decoder_velocity_tb;

    localparam int CLK_PERIOD  = 20;
    localparam int STALL_LIMIT = 4000;
    localparam int DIV_SHIFT   = 24 - qdv_pkg::FRAC_BITS_DEF;
    localparam logic [127:0] TWO_PI_FIX = 128'd26986075409;
    localparam logic [qdv_pkg::MODE_W-1:0] MODE_HOLD = 2'd3;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] angle;
        logic [31:0] velocity;
    } shaft_reading_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [qdv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [qdv_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [qdv_pkg::MODE_W-1:0]     s_mode = qdv_pkg::MODE_EDGE_A;
    logic                           s_level_a = 1'b0;
    logic                           s_level_b = 1'b0;
    logic [31:0]                    s_time_us = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic signed [31:0]             m_position_count;
    logic signed [31:0]             m_angle_rad;
    logic signed [31:0]             m_velocity_rad_s;

    // decoder state as predicted
    logic [31:0] enc_count;
    logic [31:0] prev_tick_time;
    logic [31:0] prev_tick_angle;
    logic [31:0] vel_q16;
    logic [15:0] cfg_cpr;
    logic [15:0] cfg_gear;
    logic        cfg_invert;

    shaft_reading_t readings_due[$];
    int error_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;

    quadrature_decoder_velocity dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_level_a        (s_level_a),
        .s_level_b        (s_level_b),
        .s_time_us        (s_time_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position_count (m_position_count),
        .m_angle_rad      (m_angle_rad),
        .m_velocity_rad_s (m_velocity_rad_s)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [31:0] clamp_q(input logic [127:0] q, input logic neg);
        if (neg) begin
            return (q > 128'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        return (q > 128'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    endfunction

    function automatic logic [31:0] shaft_angle(input logic [31:0] cnt);
        logic [127:0] mag;
        logic [127:0] divisor;
        logic         out_neg;
        mag = {96'b0, cnt[31] ? (32'd0 - cnt) : cnt};
        out_neg = cnt[31] ^ cfg_invert;
        if (mag == 0) begin
            return 32'd0;
        end
        // zero divisor register: saturate toward the sign of the count, flipped when inverted
        if (cfg_cpr == 0 || cfg_gear == 0) begin
            return clamp_q(128'h1_0000_0000, out_neg);
        end
        divisor = ({112'b0, cfg_cpr} * {112'b0, cfg_gear}) << DIV_SHIFT;
        return clamp_q((mag * TWO_PI_FIX + (divisor >> 1)) / divisor, out_neg);
    endfunction

    function automatic shaft_reading_t decode_event(input logic [qdv_pkg::MODE_W-1:0] mode,
                                                    input logic a, input logic b,
                                                    input logic [31:0] t);
        shaft_reading_t r;
        logic [31:0] dt;
        logic [63:0] dth;
        logic [63:0] vmag;
        case (mode)
            qdv_pkg::MODE_EDGE_A:
                enc_count = (a != b) ? enc_count + 32'd1 : enc_count - 32'd1;
            qdv_pkg::MODE_EDGE_B:
                enc_count = (a == b) ? enc_count + 32'd1 : enc_count - 32'd1;
            default: ;
        endcase
        r.angle = shaft_angle(enc_count);
        if (mode == qdv_pkg::MODE_TICK) begin
            dt = t - prev_tick_time;
            // zero time step keeps the old velocity
            if (dt != 0) begin
                dth = {{32{r.angle[31]}}, r.angle}
                    - {{32{prev_tick_angle[31]}}, prev_tick_angle};
                vmag = (dth[63] ? (64'd0 - dth) : dth) * 64'd1000000;
                vel_q16 = clamp_q({64'b0, (vmag + 64'(dt >> 1)) / 64'(dt)}, dth[63]);
            end
            prev_tick_time = t;
            prev_tick_angle = r.angle;
        end
        r.count = enc_count;
        r.velocity = vel_q16;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : track_and_check
        shaft_reading_t want;
        if (!aresetn) begin
            enc_count = '0;
            prev_tick_time = '0;
            prev_tick_angle = '0;
            vel_q16 = '0;
            cfg_cpr = qdv_pkg::CPR_RESET;
            cfg_gear = qdv_pkg::GEAR_RESET;
            cfg_invert = 1'b0;
            readings_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    qdv_pkg::CFG_COUNTS_PER_REV: cfg_cpr = cfg_wdata;
                    qdv_pkg::CFG_GEAR_RATIO_Q8:  cfg_gear = cfg_wdata;
                    qdv_pkg::CFG_INVERT_DIR:     cfg_invert = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                readings_due.push_back(decode_event(s_mode, s_level_a, s_level_b, s_time_us));
            end
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("result with nothing pending", m_position_count, '0);
                end else begin
                    want = readings_due.pop_front();
                    if (m_position_count !== want.count)
                        report_mismatch("position_count", m_position_count, want.count);
                    if (m_angle_rad !== want.angle)
                        report_mismatch("angle_rad", m_angle_rad, want.angle);
                    if (m_velocity_rad_s !== want.velocity)
                        report_mismatch("velocity_rad_s", m_velocity_rad_s, want.velocity);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("quadrature_decoder_velocity_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_event(input logic [qdv_pkg::MODE_W-1:0] mode, input logic a,
                              input logic b, input logic [31:0] t);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_level_a <= a;
        s_level_b <= b;
        s_time_us <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold off until every pending result has been taken
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (readings_due.size() != 0) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] cpr, input logic [15:0] gear,
                              input logic inv);
        cfg_wr_en <= 1'b1;
        cfg_index <= qdv_pkg::CFG_COUNTS_PER_REV;
        cfg_wdata <= cpr;
        @(posedge aclk);
        cfg_index <= qdv_pkg::CFG_GEAR_RATIO_Q8;
        cfg_wdata <= gear;
        @(posedge aclk);
        cfg_index <= qdv_pkg::CFG_INVERT_DIR;
        cfg_wdata <= {15'b0, inv};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // every level combination on both channels, then a hold and a zero-step tick
    task automatic test_edge_rules();
        send_event(qdv_pkg::MODE_EDGE_A, 1'b0, 1'b0, 32'h0000_0000);
        send_event(qdv_pkg::MODE_EDGE_A, 1'b1, 1'b0, 32'hffff_ffff);
        send_event(qdv_pkg::MODE_EDGE_A, 1'b0, 1'b1, 32'h0000_0000);
        send_event(qdv_pkg::MODE_EDGE_A, 1'b1, 1'b1, 32'hffff_ffff);
        send_event(qdv_pkg::MODE_EDGE_B, 1'b0, 1'b0, 32'h0000_0000);
        send_event(qdv_pkg::MODE_EDGE_B, 1'b1, 1'b0, 32'hffff_ffff);
        send_event(qdv_pkg::MODE_EDGE_B, 1'b0, 1'b1, 32'h0000_0000);
        send_event(qdv_pkg::MODE_EDGE_B, 1'b1, 1'b1, 32'hffff_ffff);
        send_event(MODE_HOLD, 1'b1, 1'b1, 32'hffff_ffff);
        send_event(qdv_pkg::MODE_TICK, 1'b1, 1'b1, 32'h0000_0000);
    endtask

    // time wrap, repeated timestamp and saturating velocity
    task automatic test_velocity_cases();
        send_event(qdv_pkg::MODE_EDGE_A, 1'b1, 1'b0, 32'hffff_ffff);
        send_event(qdv_pkg::MODE_TICK, 1'b0, 1'b0, 32'hffff_fff0);
        send_event(qdv_pkg::MODE_EDGE_B, 1'b1, 1'b1, 32'h0000_0000);
        send_event(qdv_pkg::MODE_TICK, 1'b1, 1'b0, 32'h0000_0005);
        send_event(qdv_pkg::MODE_TICK, 1'b0, 1'b1, 32'h0000_0005);
        send_event(qdv_pkg::MODE_EDGE_A, 1'b1, 1'b1, 32'h0000_0000);
        send_event(qdv_pkg::MODE_EDGE_A, 1'b1, 1'b1, 32'h0000_0000);
        send_event(qdv_pkg::MODE_EDGE_A, 1'b1, 1'b1, 32'h0000_0000);
        send_event(qdv_pkg::MODE_TICK, 1'b0, 1'b0, 32'h0000_0006);
    endtask

    task automatic test_divisor_extremes();
        wait_idle();
        set_config(16'd0, 16'd256, 1'b0);
        send_event(MODE_HOLD, 1'b0, 1'b0, 32'h0000_0000);
        wait_idle();
        set_config(16'd1, 16'd0, 1'b1);
        send_event(MODE_HOLD, 1'b0, 1'b0, 32'h0000_0000);
        send_event(qdv_pkg::MODE_EDGE_A, 1'b1, 1'b0, 32'h0000_0000);
        wait_idle();
        set_config(16'd65535, 16'd65535, 1'b1);
        send_event(qdv_pkg::MODE_EDGE_A, 1'b0, 1'b1, 32'h0000_0000);
        send_event(qdv_pkg::MODE_TICK, 1'b0, 1'b0, 32'h0000_1000);
    endtask

    // encoder walks in runs of random direction, with ticks and some garbage events
    task automatic test_random_walk();
        int phase;
        int seg;
        int n;
        int pick;
        int run_left;
        logic fwd;
        logic trk_a;
        logic trk_b;
        logic toggle_a;
        logic [31:0] now_us;
        logic [31:0] step_us;
        logic [15:0] cpr;
        logic [15:0] gear;
        trk_a = 1'b0;
        trk_b = 1'b0;
        fwd = 1'b1;
        run_left = 0;
        now_us = $urandom();
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0; sink_stall_pct = 0; end
                1: begin src_idle_pct = 45; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 45; end
                default: begin src_idle_pct = 8; sink_stall_pct = 8; end
            endcase
            for (seg = 0; seg < 2; seg++) begin
                case ($urandom_range(0, 3))
                    0: cpr = 16'd1;
                    1: cpr = 16'd65535;
                    2: cpr = 16'($urandom_range(1, 64));
                    default: cpr = 16'($urandom_range(1, 65535));
                endcase
                case ($urandom_range(0, 3))
                    0: gear = 16'd1;
                    1: gear = 16'd256;
                    2: gear = 16'd65535;
                    default: gear = 16'($urandom_range(1, 65535));
                endcase
                if (phase == 0 && seg == 0) begin
                    cpr = 16'd1;
                    gear = 16'd1;
                end else if (phase == 3 && seg == 1) begin
                    cpr = 16'd65535;
                    gear = 16'd65535;
                end
                wait_idle();
                set_config(cpr, gear, 1'($urandom_range(0, 1)));
                for (n = 0; n < 250; n++) begin
                    if ($urandom_range(0, 99) == 0)
                        wait_idle();
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        if (run_left == 0) begin
                            fwd = 1'($urandom_range(0, 1));
                            run_left = $urandom_range(1, 40);
                        end
                        run_left--;
                        toggle_a = ((trk_a == trk_b) == fwd);
                        if (toggle_a)
                            trk_a = ~trk_a;
                        else
                            trk_b = ~trk_b;
                        send_event(toggle_a ? qdv_pkg::MODE_EDGE_A : qdv_pkg::MODE_EDGE_B,
                                   trk_a, trk_b, $urandom());
                    end else if (pick < 85) begin
                        case ($urandom_range(0, 9))
                            0: step_us = 32'd0;
                            1: step_us = $urandom();
                            default: step_us = $urandom_range(1, 2000);
                        endcase
                        now_us += step_us;
                        send_event(qdv_pkg::MODE_TICK, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), now_us);
                    end else begin
                        trk_a = 1'($urandom_range(0, 1));
                        trk_b = 1'($urandom_range(0, 1));
                        send_event(qdv_pkg::MODE_W'($urandom_range(0, 3)), trk_a, trk_b,
                                   $urandom());
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_edge_rules();
        test_velocity_cases();
        test_divisor_extremes();
        test_random_walk();
        wait_idle();
        repeat (300) @(posedge aclk);
        if (error_count == 0) begin
            $display("quadrature_decoder_velocity_tb: clean");
        end else begin
            $display("quadrature_decoder_velocity_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/qdv_pkg.sv
hw/rtl/quadrature_decoder_velocity.sv
sim/quadrature_decoder_velocity_tb.sv
